/* hw/rtl/thl_pkg.sv */
// ----------------------------------------------------------------------------
// thl_pkg: shared types and constants for the tile height lookup unit
// Opcodes, register indexes, field widths and controller-datapath bundles.
// ----------------------------------------------------------------------------
package thl_pkg;

  localparam int MAP_CELLS_DEF    = 4096;
  localparam int TILE_ENTRIES_DEF = 64;
  localparam int FRAC_BITS_DEF    = 4;

  localparam int POS_W  = 20;
  localparam int HGT_W  = 16;
  localparam int KIND_W = 8;
  localparam int SLOT_W = 12;
  localparam int SIZE_W = 8;
  localparam int CNT_W  = 13;
  localparam int ENT_W  = 7;
  localparam int QUO_W  = 20;

  localparam logic [1:0] OP_MAP_WR  = 2'd0;
  localparam logic [1:0] OP_TILE_WR = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [2:0] REG_TILE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TILE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MAP_COLUMNS = 3'd2;
  localparam logic [2:0] REG_MAP_CELLS   = 3'd3;
  localparam logic [2:0] REG_TILE_COUNT  = 3'd4;

  typedef struct packed {
    logic load;      // capture item, start both divisions
    logic div_step;  // one restoring-division step on both axes
    logic idx_calc;  // form cell index
    logic map_rd;    // issue map read
    logic scan_start;
    logic scan_step; // read next table entry
    logic hit_save;  // keep height of matching entry
    logic res_load;  // latch result
    logic res_ok;
  } thl_cmd_t;

  typedef struct packed {
    logic pre_fail;   // empty, negative or zero tile size
    logic idx_fail;   // index out of range
    logic kind_zero;
    logic hit;        // table entry matches
    logic scan_last;  // entry just compared was the last in use
  } thl_sts_t;

endpackage

/* hw/rtl/thl_ram.sv */
// ----------------------------------------------------------------------------
// thl_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module thl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hw/rtl/thl_datapath.sv */
// ----------------------------------------------------------------------------
// thl_datapath: storage, dividers, index and table scan
// Holds config, map and tile RAMs, two bit-serial dividers and the result.
// ----------------------------------------------------------------------------
module thl_datapath
  import thl_pkg::*;
#(
  parameter int MAP_CELLS    = MAP_CELLS_DEF,
  parameter int TILE_ENTRIES = TILE_ENTRIES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             wr_en,
  input  logic [1:0]       wr_op,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [KIND_W-1:0] wr_kind,
  input  logic [HGT_W-1:0]  wr_height,
  input  logic [POS_W-1:0]  q_pos_x,
  input  logic [POS_W-1:0]  q_pos_y,
  input  thl_cmd_t         cmd,
  output thl_sts_t         sts,
  output logic [HGT_W-1:0] res_height,
  output logic             res_found
);
  localparam int MAP_AW = $clog2(MAP_CELLS);
  localparam int TE_AW  = (TILE_ENTRIES > 1) ? $clog2(TILE_ENTRIES) : 1;
  localparam int TE_CW  = $clog2(TILE_ENTRIES + 1);
  localparam int MC_CW  = $clog2(MAP_CELLS + 1);
  localparam int IDX_W  = QUO_W + CNT_W + 1;

  logic [SIZE_W-1:0] tw_r, th_r;
  logic [CNT_W-1:0]  cols_r, cells_r;
  logic [ENT_W-1:0]  ents_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= SIZE_W'(32); th_r <= SIZE_W'(32); cols_r <= CNT_W'(64);
      cells_r <= '0; ents_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TILE_WIDTH:  tw_r <= cfg_wdata[SIZE_W-1:0];
        REG_TILE_HEIGHT: th_r <= cfg_wdata[SIZE_W-1:0];
        REG_MAP_COLUMNS: cols_r <= cfg_wdata;
        REG_MAP_CELLS:   cells_r <= cfg_wdata;
        REG_TILE_COUNT:  ents_r <= cfg_wdata[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [MC_CW-1:0] cells_eff;
  logic [TE_CW-1:0] ents_eff;
  assign cells_eff = (32'(cells_r) > MAP_CELLS) ? MC_CW'(MAP_CELLS) : MC_CW'(cells_r);
  assign ents_eff  = (32'(ents_r) > TILE_ENTRIES) ? TE_CW'(TILE_ENTRIES) : TE_CW'(ents_r);

  // bit-serial restoring dividers, MSB first
  logic [QUO_W-1:0]  qx_r, qy_r;
  logic [SIZE_W:0]   rx_r, ry_r;
  logic [QUO_W-1:0]  wx, wy;
  logic [SIZE_W:0]   tx, ty;
  assign wx = QUO_W'(q_pos_x[POS_W-2:0] >> FRAC_BITS) + QUO_W'(tw_r >> 1);
  assign wy = QUO_W'(q_pos_y[POS_W-2:0] >> FRAC_BITS) + QUO_W'(th_r >> 1);
  assign tx = {rx_r[SIZE_W-1:0], qx_r[QUO_W-1]};
  assign ty = {ry_r[SIZE_W-1:0], qy_r[QUO_W-1]};

  logic [IDX_W-1:0] idx_r;
  logic [QUO_W+CNT_W-1:0] row_prod;
  logic [KIND_W-1:0] want_r;
  logic [TE_AW-1:0]  scan_r;
  logic [TE_CW-1:0]  cmp_cnt_r;
  logic [HGT_W-1:0]  hit_hgt_r;
  logic              fail_r;

  assign row_prod = qy_r * cols_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_r <= wx; qy_r <= wy; rx_r <= '0; ry_r <= '0;
      fail_r <= (cells_eff == '0) || (ents_eff == '0) || q_pos_x[POS_W-1]
                || q_pos_y[POS_W-1] || (tw_r == '0) || (th_r == '0);
    end else if (cmd.div_step) begin
      if (tx >= {1'b0, tw_r}) begin
        rx_r <= tx - {1'b0, tw_r}; qx_r <= {qx_r[QUO_W-2:0], 1'b1};
      end else begin
        rx_r <= tx; qx_r <= {qx_r[QUO_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, th_r}) begin
        ry_r <= ty - {1'b0, th_r}; qy_r <= {qy_r[QUO_W-2:0], 1'b1};
      end else begin
        ry_r <= ty; qy_r <= {qy_r[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.idx_calc) begin
      idx_r <= IDX_W'(row_prod) + IDX_W'(qx_r);
    end
  end

  // map RAM
  logic [KIND_W-1:0] map_q;
  logic              map_we;
  logic [MAP_AW-1:0] map_addr;
  assign map_we   = wr_en && (wr_op == OP_MAP_WR) && (32'(wr_slot) < MAP_CELLS);
  assign map_addr = cmd.map_rd ? idx_r[MAP_AW-1:0] : MAP_AW'(wr_slot);

  thl_ram #(.WIDTH(KIND_W), .DEPTH(MAP_CELLS)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(wr_kind), .rdata(map_q)
  );

  // tile table RAMs
  logic [KIND_W-1:0] tk_q;
  logic [HGT_W-1:0]  th_q;
  logic              te_we;
  logic [TE_AW-1:0]  te_addr;
  assign te_we   = wr_en && (wr_op == OP_TILE_WR) && (32'(wr_slot) < TILE_ENTRIES);
  assign te_addr = cmd.scan_start ? '0 : (cmd.scan_step ? scan_r : TE_AW'(wr_slot));

  thl_ram #(.WIDTH(KIND_W), .DEPTH(TILE_ENTRIES)) u_tkind (
    .clk(clk), .we(te_we), .addr(te_addr), .wdata(wr_kind), .rdata(tk_q)
  );
  thl_ram #(.WIDTH(HGT_W), .DEPTH(TILE_ENTRIES)) u_thgt (
    .clk(clk), .we(te_we), .addr(te_addr), .wdata(wr_height), .rdata(th_q)
  );

  // scan_start: map data valid, first entry read; scan_step: compare & read next
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      want_r    <= map_q - KIND_W'(1);
      scan_r    <= TE_AW'(1);
      cmp_cnt_r <= TE_CW'(1);
    end else if (cmd.scan_step) begin
      scan_r    <= scan_r + TE_AW'(1);
      cmp_cnt_r <= cmp_cnt_r + TE_CW'(1);
    end
    if (cmd.hit_save) begin
      hit_hgt_r <= th_q;
    end
  end
  assign sts.pre_fail  = fail_r;
  assign sts.idx_fail  = idx_r >= IDX_W'(cells_eff);
  assign sts.kind_zero = (map_q == '0);
  assign sts.hit       = (tk_q == want_r);
  assign sts.scan_last = (cmp_cnt_r >= ents_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_found <= 1'b0; res_height <= '0;
    end else if (cmd.res_load) begin
      res_found  <= cmd.res_ok;
      res_height <= cmd.res_ok ? hit_hgt_r : '0;
    end
  end
endmodule

/* hw/rtl/thl_ctrl.sv */
// ----------------------------------------------------------------------------
// thl_ctrl: query sequencer
// Steps divide, index, map read and table scan; owns the output handshake.
// ----------------------------------------------------------------------------
module thl_ctrl
  import thl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_xfer,
  input  logic     is_query,
  input  thl_sts_t sts,
  output thl_cmd_t cmd_out,
  output logic     busy,
  output logic     out_tvalid,
  input  logic     out_tready
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_IDX  = 3'd2;
  localparam logic [2:0] ST_MAP  = 3'd3;
  localparam logic [2:0] ST_KIND = 3'd4;
  localparam logic [2:0] ST_SCAN = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;
  thl_cmd_t   cmd;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    if (out_tvalid && out_tready) pend_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          cmd.load = 1'b1; cnt_nxt = '0; state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(QUO_W - 1)) state_nxt = ST_IDX;
      end
      ST_IDX: begin
        cmd.idx_calc = 1'b1; state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (sts.pre_fail || sts.idx_fail) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.map_rd = 1'b1; state_nxt = ST_KIND;
        end
      end
      ST_KIND: begin
        if (sts.kind_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.scan_start = 1'b1; state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_nxt = ST_OUT; cmd.res_ok = 1'b1; cmd.hit_save = 1'b1;
        end else if (sts.scan_last) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!pend_r || (out_tvalid && out_tready)) begin
          state_nxt = ST_IDLE; pend_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_SCAN && (sts.hit || sts.scan_last)) cmd.res_load = 1'b0;
  end

  // result register loads when leaving OUT; ok flag carried from scan
  logic ok_r;
  thl_cmd_t cmd_q;
  always_comb begin
    cmd_q = cmd;
    if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      cmd_q.res_load = 1'b1; cmd_q.res_ok = ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; pend_r <= 1'b0; ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; pend_r <= pend_nxt;
      if (cmd.load) ok_r <= 1'b0;
      else if (cmd.res_ok) ok_r <= 1'b1;
    end
  end

  assign out_tvalid = pend_r;
  assign busy       = (state_r != ST_IDLE);

  // result register fed through cmd_q; res_ok inside scan is only a flag
  assign cmd_out = cmd_q;

  property p_no_load_busy;
    @(posedge clk) disable iff (!rst_n) busy |-> !cmd_out.load;
  endproperty
  a_no_load_busy: assert property (p_no_load_busy) else $error("load while busy");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDX) |-> $past(state_r) == ST_DIV) else $error("divide skipped");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_tready) |=> pend_r) else $error("result dropped");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.idx_calc, cmd.map_rd, cmd.scan_start}))
    else $error("command overlap");
endmodule

/* hw/rtl/tile_height_lookup_unit.sv */
// ----------------------------------------------------------------------------
// tile_height_lookup_unit: tile map and tile table with position height query
// Usage:
//   in_* stream carries one operation per transfer. Map and table writes are
//   taken every cycle while no query is in progress and give no result.
//   A query gives one out_* transfer: height and found flag.
//   Query steps, from the accepting edge to out_tvalid: a bit-serial divide
//   (both axes in parallel, one quotient bit per cycle), an index multiply,
//   one map RAM read, then the table is scanned one entry per cycle from
//   entry 0 until a match or the last entry in use. A query that fails
//   the checks before the scan, or finds a zero cell kind, skips the scan.
//   While a query runs in_tready is low. A finished result sits in the output
//   register; the next query may run while it waits, and only its own result
//   hand-off stalls until out_tready takes the earlier one.
//   cfg_* writes take effect on the next edge. They must only be made when
//   idle (block does not check). Reset loads defaults, RAMs are not cleared.
// ----------------------------------------------------------------------------
module tile_height_lookup_unit
  import thl_pkg::*;
#(
  parameter int MAP_CELLS    = MAP_CELLS_DEF,
  parameter int TILE_ENTRIES = TILE_ENTRIES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // op, slot, kind, height_in, pos_x, pos_y
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [23:0] out_tdata   // height_out, found
);
  thl_cmd_t cmd;
  thl_sts_t sts;
  logic busy, in_xfer, res_found;
  logic [HGT_W-1:0] res_height;

  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;

  thl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_xfer(in_xfer),
    .is_query(in_tdata[1:0] == OP_QUERY), .sts(sts), .cmd_out(cmd),
    .busy(busy), .out_tvalid(out_tvalid), .out_tready(out_tready)
  );

  thl_datapath #(
    .MAP_CELLS(MAP_CELLS), .TILE_ENTRIES(TILE_ENTRIES), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .wr_en(in_xfer), .wr_op(in_tdata[1:0]),
    .wr_slot(in_tdata[13:2]), .wr_kind(in_tdata[21:14]),
    .wr_height(in_tdata[37:22]), .q_pos_x(in_tdata[57:38]),
    .q_pos_y(in_tdata[77:58]), .cmd(cmd), .sts(sts),
    .res_height(res_height), .res_found(res_found)
  );

  assign out_tdata = {7'd0, res_found, res_height};
endmodule
